@@ rtl/stlt_pkg.sv @@
// Shared types and command codes for the session table.
package stlt_pkg;

  localparam int CMD_W     = 3;
  localparam int TOKEN_W   = 64;
  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 20;
  localparam int SLOT_W    = 4;

  localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_VALIDATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DESTROY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INIT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 3'd4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd3600;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TOKEN_W-1:0] token;
    logic [TIME_W-1:0]  now;
  } stlt_req_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [TOKEN_W-1:0] issued_token;
  } stlt_rsp_t;

endpackage

@@ rtl/session_table_lru_ttl.sv @@
// Session table with LRU eviction on create and idle timeout on validate.
//
// Requests enter on in_valid/in_ready with command, token and current time;
// one response per request leaves on out_valid/out_ready. cfg_we writes the
// 20-bit idle timeout (reset value 3600); the user must use it only while
// idle, which the block does not enforce. Create, validate and destroy
// walk the table one entry per cycle through a single read port of the
// token/time memory and one shared age subtractor with its compares. A walk
// issues one registered read per entry, evaluates each entry when its
// read data is back, and ends with a write-back. It ends early at the
// first empty slot (create) or at the first match (validate, destroy).
// in_ready returns the cycle after write-back. Init, shutdown, unknown
// codes and commands to a disabled table skip the walk and go straight
// to write-back.
// in_ready is high only while no request is in flight; a waiting response
// sits in the output register, so the next request is taken meanwhile, and
// the write-back of that one waits until the output register is free.
// Reset empties the table, disables it and restores the timeout. Token and
// time storage is not cleared; per-entry valid bits mark live entries.
module session_table_lru_ttl #(
  parameter int NUM_SESSIONS = 16,
  parameter int TOKEN_BITS   = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  stlt_pkg::stlt_req_t         in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output stlt_pkg::stlt_rsp_t         out_data,
  input  logic                        cfg_we,
  input  logic [stlt_pkg::TIMEOUT_W-1:0] cfg_wdata
);
  import stlt_pkg::*;

  localparam int IDX_W = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SESSIONS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Token and last-active storage
  logic [TOKEN_BITS-1:0] mem_tok  [NUM_SESSIONS];
  logic [TIME_W-1:0]     mem_time [NUM_SESSIONS];

  logic [1:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    iss_r, iss_nxt;
  logic                    ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]        ev_idx_r, ev_idx_nxt;
  logic                    have_old_r, have_old_nxt;
  logic [IDX_W-1:0]        old_idx_r, old_idx_nxt;
  logic [TIME_W-1:0]       old_age_r, old_age_nxt;
  logic                    ok_r, ok_nxt;
  logic [IDX_W-1:0]        pick_r, pick_nxt;
  logic                    evict_r, evict_nxt;
  logic [NUM_SESSIONS-1:0] valid_r, valid_nxt;
  logic                    enabled_r, enabled_nxt;
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [TOKEN_BITS-1:0]   tok_r, tok_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [TIMEOUT_W-1:0]    timeout_r, timeout_nxt;
  logic                    out_valid_r, out_valid_nxt;
  stlt_rsp_t               out_data_r, out_data_nxt;

  logic [TOKEN_BITS-1:0] rd_tok_r;
  logic [TIME_W-1:0]     rd_time_r;

  logic                  in_fire;
  logic                  done_fire;
  logic [TIME_W-1:0]     age;
  logic                  ev_live;
  logic                  tok_eq;
  logic                  older;
  logic [31:0]           slot_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared age unit and compares for the entry being evaluated
  assign age     = now_r - rd_time_r;
  assign ev_live = valid_r[ev_idx_r];
  assign tok_eq  = (rd_tok_r == tok_r);
  assign older   = !have_old_r || (age > old_age_r);
  assign slot_ext = 32'(pick_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    iss_nxt       = iss_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    have_old_nxt  = have_old_r;
    old_idx_nxt   = old_idx_r;
    old_age_nxt   = old_age_r;
    ok_nxt        = ok_r;
    pick_nxt      = pick_r;
    evict_nxt     = evict_r;
    valid_nxt     = valid_r;
    enabled_nxt   = enabled_r;
    cmd_nxt       = cmd_r;
    tok_nxt       = tok_r;
    now_nxt       = now_r;
    timeout_nxt   = cfg_we ? cfg_wdata : timeout_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_data.command;
          tok_nxt      = in_data.token[TOKEN_BITS-1:0];
          now_nxt      = in_data.now;
          idx_nxt      = '0;
          iss_nxt      = 1'b1;
          have_old_nxt = 1'b0;
          old_idx_nxt  = '0;
          old_age_nxt  = '0;
          ok_nxt       = 1'b0;
          pick_nxt     = '0;
          evict_nxt    = 1'b0;
          if ((in_data.command inside {CMD_CREATE, CMD_VALIDATE, CMD_DESTROY})
              && enabled_r) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
            if (in_data.command == CMD_INIT) begin
              valid_nxt   = '0;
              enabled_nxt = 1'b1;
              ok_nxt      = 1'b1;
            end else if (in_data.command == CMD_SHUTDOWN) begin
              valid_nxt   = '0;
              enabled_nxt = 1'b0;
            end
          end
        end
      end

      S_SCAN: begin
        // issue the next read
        if (iss_r) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // evaluate the entry read last cycle
        if (ev_vld_r) begin
          case (cmd_r)
            CMD_CREATE: begin
              if (!ev_live) begin
                ok_nxt    = 1'b1;
                pick_nxt  = ev_idx_r;
                state_nxt = S_DONE;
              end else begin
                if (older) begin
                  have_old_nxt = 1'b1;
                  old_idx_nxt  = ev_idx_r;
                  old_age_nxt  = age;
                end
                if (ev_idx_r == LAST_IDX) begin
                  ok_nxt    = 1'b1;
                  evict_nxt = 1'b1;
                  pick_nxt  = older ? ev_idx_r : old_idx_r;
                  state_nxt = S_DONE;
                end
              end
            end
            CMD_VALIDATE: begin
              if (ev_live && (age > TIME_W'(timeout_r))) begin
                valid_nxt[ev_idx_r] = 1'b0;
              end else if (ev_live && tok_eq) begin
                ok_nxt    = 1'b1;
                pick_nxt  = ev_idx_r;
                state_nxt = S_DONE;
              end
              if (ev_idx_r == LAST_IDX) begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              if (ev_live && tok_eq) begin
                ok_nxt    = 1'b1;
                pick_nxt  = ev_idx_r;
                state_nxt = S_DONE;
              end
              if (ev_idx_r == LAST_IDX) begin
                state_nxt = S_DONE;
              end
            end
          endcase
          if (state_nxt == S_DONE) begin
            iss_nxt    = 1'b0;
            ev_vld_nxt = 1'b0;
          end
        end
      end

      S_DONE: begin
        if (done_fire) begin
          state_nxt                 = S_IDLE;
          out_valid_nxt             = 1'b1;
          out_data_nxt.ok           = ok_r;
          out_data_nxt.slot         = ok_r ? slot_ext[SLOT_W-1:0] : '0;
          out_data_nxt.evicted      = evict_r;
          out_data_nxt.issued_token = '0;
          if (ok_r && (cmd_r == CMD_CREATE)) begin
            out_data_nxt.issued_token = TOKEN_W'(tok_r);
            valid_nxt[pick_r]         = 1'b1;
          end else if (ok_r && (cmd_r == CMD_DESTROY)) begin
            valid_nxt[pick_r] = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= 1'b0;
      ev_vld_r    <= 1'b0;
      have_old_r  <= 1'b0;
      ok_r        <= 1'b0;
      evict_r     <= 1'b0;
      valid_r     <= '0;
      enabled_r   <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      ev_vld_r    <= ev_vld_nxt;
      have_old_r  <= have_old_nxt;
      ok_r        <= ok_nxt;
      evict_r     <= evict_nxt;
      valid_r     <= valid_nxt;
      enabled_r   <= enabled_nxt;
      timeout_r   <= timeout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    old_idx_r  <= old_idx_nxt;
    old_age_r  <= old_age_nxt;
    pick_r     <= pick_nxt;
    cmd_r      <= cmd_nxt;
    tok_r      <= tok_nxt;
    now_r      <= now_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table memory: one registered read per scan cycle while reads are issued, writes at write-back
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && iss_r) begin
      rd_tok_r  <= mem_tok[idx_r];
      rd_time_r <= mem_time[idx_r];
    end
    if (done_fire && ok_r && (cmd_r == CMD_CREATE)) begin
      mem_tok[pick_r]  <= tok_r;
      mem_time[pick_r] <= now_r;
    end else if (done_fire && ok_r && (cmd_r == CMD_VALIDATE)) begin
      mem_time[pick_r] <= now_r;
    end
  end

endmodule

@@ sim/stlt_checker.sv @@
// Session table checker: tracks the table, predicts each response and compares it.
`timescale 1ns / 100ps

module stlt_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  stlt_pkg::stlt_req_t            in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  stlt_pkg::stlt_rsp_t            out_data,
  input  logic                           cfg_we,
  input  logic [stlt_pkg::TIMEOUT_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             due_count
);
  import stlt_pkg::*;

  localparam int ENTRIES = 16;

  logic                 sess_valid [ENTRIES];
  logic [TOKEN_W-1:0]   sess_token [ENTRIES];
  logic [TIME_W-1:0]    sess_last  [ENTRIES];
  logic                 table_on;
  logic [TIMEOUT_W-1:0] idle_limit;

  stlt_rsp_t rsp_due[$];

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  task automatic wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      sess_valid[i] = 1'b0;
      sess_token[i] = '0;
      sess_last[i]  = '0;
    end
  endtask

  task automatic apply_request(input stlt_req_t r, output stlt_rsp_t rsp);
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest_age;
    int                pick;
    int                oldest;
    bit                have_old;
    rsp        = '0;
    pick       = -1;
    oldest     = 0;
    oldest_age = '0;
    have_old   = 1'b0;
    case (r.command)
      CMD_INIT: begin
        wipe_table();
        table_on = 1'b1;
        rsp.ok   = 1'b1;
      end
      CMD_SHUTDOWN: begin
        wipe_table();
        table_on = 1'b0;
      end
      CMD_CREATE: begin
        if (table_on) begin
          // first empty slot wins, else the oldest live one, lowest index on ties
          for (int i = 0; i < ENTRIES; i++) begin
            if (pick < 0) begin
              if (!sess_valid[i]) begin
                pick = i;
              end else begin
                age = r.now - sess_last[i];
                if (!have_old || age > oldest_age) begin
                  oldest_age = age;
                  oldest     = i;
                  have_old   = 1'b1;
                end
              end
            end
          end
          if (pick < 0) begin
            pick        = oldest;
            rsp.evicted = 1'b1;
          end
          sess_valid[pick] = 1'b1;
          sess_token[pick] = r.token;
          sess_last[pick]  = r.now;
          rsp.ok           = 1'b1;
          rsp.slot         = SLOT_W'(pick);
          rsp.issued_token = r.token;
        end
      end
      CMD_VALIDATE: begin
        if (table_on) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (pick < 0 && sess_valid[i]) begin
              age = r.now - sess_last[i];
              if (age > {{(TIME_W-TIMEOUT_W){1'b0}}, idle_limit}) begin
                // drop expired entries passed on the way
                sess_valid[i] = 1'b0;
                sess_token[i] = '0;
                sess_last[i]  = '0;
              end else if (sess_token[i] == r.token) begin
                sess_last[i] = r.now;
                rsp.ok       = 1'b1;
                rsp.slot     = SLOT_W'(i);
                pick         = i;
              end
            end
          end
        end
      end
      CMD_DESTROY: begin
        if (table_on) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (pick < 0 && sess_valid[i] && sess_token[i] == r.token) begin
              sess_valid[i] = 1'b0;
              sess_token[i] = '0;
              sess_last[i]  = '0;
              rsp.ok        = 1'b1;
              rsp.slot      = SLOT_W'(i);
              pick          = i;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    stlt_rsp_t want;
    stlt_rsp_t pred;
    if (!rst_n) begin
      wipe_table();
      table_on   = 1'b0;
      idle_limit = TIMEOUT_RESET;
      rsp_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rsp_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected response: ok=%0d slot=%0d evicted=%0d token=%h",
                     out_data.ok, out_data.slot, out_data.evicted, out_data.issued_token);
          fail_count++;
        end else begin
          want = rsp_due.pop_front();
          if (out_data.ok !== want.ok || out_data.slot !== want.slot ||
              out_data.evicted !== want.evicted ||
              out_data.issued_token !== want.issued_token) begin
            if (fail_count < 10) begin
              $display("mismatch: want ok=%0d slot=%0d evicted=%0d token=%h",
                       want.ok, want.slot, want.evicted, want.issued_token);
              $display("          got  ok=%0d slot=%0d evicted=%0d token=%h",
                       out_data.ok, out_data.slot, out_data.evicted, out_data.issued_token);
            end
            fail_count++;
          end
        end
      end
      if (cfg_we)
        idle_limit = cfg_wdata;
      if (in_valid && in_ready) begin
        apply_request(in_data, pred);
        rsp_due.push_back(pred);
      end
    end
    due_count = rsp_due.size();
  end

endmodule

@@ sim/tb.sv @@
// Session table testbench top: clock, reset, request stimulus and final verdict.
`timescale 1ns / 100ps

module tb;
  import stlt_pkg::*;

  localparam int LIMIT      = 500000;
  localparam int PHASE_REQS = 96;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  stlt_req_t            in_data;
  logic                 out_valid;
  logic                 out_ready;
  stlt_rsp_t            out_data;
  logic                 cfg_we;
  logic [TIMEOUT_W-1:0] cfg_wdata;

  int fail_count;
  int due_count;
  int cycles;
  int burst_left;
  int stall_mode;
  int stall_left;

  logic [TIMEOUT_W-1:0] phase_limit [5];

  session_table_lru_ttl u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stlt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("session_table_lru_ttl verification failed");
      $finish;
    end
  end

  // receiver: runs of ready, runs of stall, and runs of coin flips
  initial begin
    out_ready  = 1'b0;
    stall_mode = 0;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = 1'b0;
      default: out_ready = $urandom_range(0, 1);
    endcase
  end

  // called just after a falling edge; returns just after a falling edge once in_ready has taken the request
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TOKEN_W-1:0] tok,
                              input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(0, 9) == 0 ? $urandom_range(13, 60) : $urandom_range(0, 12);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid        = 1'b1;
    in_data.command = cmd;
    in_data.token   = tok;
    in_data.now     = now;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic run_phase(input logic [TIMEOUT_W-1:0] lim);
    logic [TOKEN_W-1:0] token_pool [8];
    logic [TOKEN_W-1:0] tok;
    logic [TIME_W-1:0]  cur_time;
    logic [CMD_W-1:0]   cmd;
    int                 done;
    int                 r;
    cur_time = $urandom;
    for (int i = 0; i < 8; i++)
      token_pool[i] = {$urandom, $urandom};
    send_request(CMD_INIT, token_pool[0], cur_time);
    done = 1;
    while (done < PHASE_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 40)      cmd = CMD_CREATE;
      else if (r < 72) cmd = CMD_VALIDATE;
      else if (r < 86) cmd = CMD_DESTROY;
      else if (r < 91) cmd = CMD_INIT;
      else if (r < 95) cmd = CMD_SHUTDOWN;
      else             cmd = CMD_W'($urandom_range(5, 7));
      tok = $urandom_range(0, 99) < 85 ? token_pool[$urandom_range(0, 7)]
                                      : {$urandom, $urandom};
      // advance time: ties, short steps, the expiry boundary, or a jump anywhere
      r = $urandom_range(0, 99);
      if (r < 50)      cur_time = cur_time + $urandom_range(0, 3);
      else if (r < 80) cur_time = cur_time + $urandom_range(0, int'(lim) / 8 + 2);
      else if (r < 93) cur_time = cur_time + $urandom_range(int'(lim), int'(lim) + 2);
      else             cur_time = $urandom;
      send_request(cmd, tok, cur_time);
      done++;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    burst_left = 0;
    phase_limit[0] = '0;
    phase_limit[1] = '1;
    phase_limit[2] = 20'd40;
    phase_limit[3] = TIMEOUT_W'($urandom_range(1, 20'hFFFFE));
    phase_limit[4] = TIMEOUT_RESET;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // disabled table refuses everything but init
    send_request(CMD_CREATE,   '1, 32'd0);
    send_request(CMD_VALIDATE, '1, 32'd0);
    send_request(CMD_DESTROY,  '1, 32'd0);
    send_request(CMD_SHUTDOWN, '0, 32'd0);
    send_request(CMD_INIT,     '0, 32'd0);
    send_request(CMD_CREATE,   '1, 32'd0);
    send_request(CMD_CREATE,   '0, 32'hFFFF_FFFF);
    // ages across the wrap of the time field
    send_request(CMD_VALIDATE, '1, 32'd100);
    send_request(CMD_VALIDATE, '0, 32'd100);
    // both entries expire on a missing token
    send_request(CMD_VALIDATE, 64'h1234, 32'd5000);
    send_request(CMD_VALIDATE, '1, 32'd5000);
    send_request(CMD_CREATE,   64'hA5A5_5A5A_0F0F_F0F0, 32'd5000);
    send_request(CMD_DESTROY,  64'hA5A5_5A5A_0F0F_F0F0, 32'd5001);
    send_request(CMD_DESTROY,  64'hA5A5_5A5A_0F0F_F0F0, 32'd5002);
    send_request(3'd5, '1, '1);
    send_request(3'd6, '0, '0);
    send_request(3'd7, '1, '1);
    send_request(CMD_CREATE,   64'h5A5A_A5A5_F0F0_0F0F, 32'h8000_0000);
    send_request(CMD_INIT,     '1, '1);
    send_request(CMD_VALIDATE, 64'h5A5A_A5A5_F0F0_0F0F, 32'h8000_0000);
    send_request(CMD_SHUTDOWN, '1, '1);
    send_request(CMD_INIT,     '0, '0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_timeout(phase_limit[p]);
      run_phase(phase_limit[p]);
      drain();
    end

    if (fail_count == 0 && due_count == 0) begin
      $display("session_table_lru_ttl verification clean");
    end else begin
      $display("session_table_lru_ttl verification failed");
    end
    $finish;
  end

endmodule
